[design/gyro_yaw_integrator_bias_track_unit_defines.svh]
// Assertion helpers used by the top-level RTL file of the yaw integrator.
`ifndef GYRO_YAW_INTEGRATOR_BIAS_TRACK_UNIT_DEFINES_SVH
`define GYRO_YAW_INTEGRATOR_BIAS_TRACK_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk, off while in reset.
`define GYIB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk, off while in reset.
`define GYIB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/gyib_pkg.sv]
`default_nettype none

package gyib_pkg;

    // Field widths
    localparam int RATE_W    = 18;
    localparam int TS_W      = 32;
    localparam int YAW_W     = 28;
    localparam int THR_W     = 17;
    localparam int HOLD_W    = 16;
    localparam int CFG_W     = 18;
    localparam int CFG_IDX_W = 2;

    // Defaults for the top-level parameters
    localparam int BIAS_FRAC_BITS_DEF = 16;
    localparam int DT_MAX_MS_DEF      = 511;

    // Register reset values
    localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(128);
    localparam logic [HOLD_W-1:0] HOLD_RESET = HOLD_W'(100);

    // 360 degrees in 1/256000 degree
    localparam int YAW_FULL_TURN = 92160000;

    // Bias tracking gain 655/65536 (~1/100)
    localparam int TRACK_SHIFT = 16;

    // Yaw sum width: |yaw| + |increment| stays below 2^29
    localparam int SUM_W = 30;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_HOLD      = 2'd1,
        REG_INIT_BIAS = 2'd2
    } cfg_idx_t;

    localparam logic REQ_SAMPLE    = 1'b0;
    localparam logic REQ_YAW_RESET = 1'b1;

    typedef struct packed {
        logic still;   // sample below threshold
        logic track;   // bias estimate moves on this word
    } gyib_flags_t;

endpackage

`default_nettype wire

[design/gyib_calc.sv]
`default_nettype none

module gyib_calc
    import gyib_pkg::*;
#(
    parameter int BIAS_FRAC_BITS = BIAS_FRAC_BITS_DEF,
    parameter int DT_MAX_MS      = DT_MAX_MS_DEF
)
(
    input  wire logic                                   req_type,
    input  wire logic signed [RATE_W-1:0]               rate,
    input  wire logic        [TS_W-1:0]                 now,
    input  wire logic signed [YAW_W-1:0]                yaw_cur,
    input  wire logic signed [RATE_W+BIAS_FRAC_BITS-1:0] bias_cur,
    input  wire logic        [TS_W-1:0]                 last_time,
    input  wire logic        [TS_W-1:0]                 still_start,
    input  wire logic                                   was_still,
    input  wire logic        [THR_W-1:0]                threshold,
    input  wire logic        [HOLD_W-1:0]               hold,
    output logic signed      [YAW_W-1:0]                yaw_new,
    output logic signed      [RATE_W+BIAS_FRAC_BITS-1:0] bias_new,
    output gyib_flags_t                                 flags
);

    localparam int BW  = RATE_W + BIAS_FRAC_BITS;
    localparam int DTW = $clog2(DT_MAX_MS + 1);
    localparam int GW  = BW + 11;
    localparam int PW  = BW + DTW + 2;
    localparam logic signed [SUM_W-1:0] TURN1 = SUM_W'(YAW_FULL_TURN);
    localparam logic signed [SUM_W-1:0] TURN2 = SUM_W'(2 * YAW_FULL_TURN);

    logic        [TS_W-1:0]   dt_raw;
    logic        [DTW-1:0]    dt;
    logic        [RATE_W-1:0] rate_u;
    logic        [RATE_W-1:0] mag;
    logic        [TS_W-1:0]   elapsed;
    logic                     sample;
    logic                     still;
    logic                     track;
    logic signed [BW-1:0]     rfx;
    logic signed [BW:0]       diff;
    logic signed [GW-1:0]     diff_g;
    logic signed [GW-1:0]     gain_prod;
    logic signed [BW:0]       bias_trk;
    logic signed [BW:0]       diff_new;
    logic signed [PW-1:0]     prod;
    logic signed [PW-1:0]     prod_rnd;
    logic signed [PW-1:0]     inc_full;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  wrapped;

    always_comb
    begin
        sample  = (req_type == REQ_SAMPLE);
        dt_raw  = now - last_time;
        dt      = (dt_raw > TS_W'(DT_MAX_MS)) ? DTW'(DT_MAX_MS) : dt_raw[DTW-1:0];
        rate_u  = rate;
        mag     = rate_u[RATE_W-1] ? (~rate_u + RATE_W'(1)) : rate_u;
        still   = sample && (mag < {1'b0, threshold});
        elapsed = now - still_start;
        // a fresh still run starts at this word, so was_still is low and it does not track yet
        track   = still && was_still && (elapsed > TS_W'(hold));

        rfx       = $signed({rate, {BIAS_FRAC_BITS{1'b0}}});
        diff      = (BW+1)'(rfx) - (BW+1)'(bias_cur);
        // x * 655 as shift-add: 512 + 128 + 16 - 1
        diff_g    = GW'(diff);
        gain_prod = (diff_g <<< 9) + (diff_g <<< 7) + (diff_g <<< 4) - diff_g;
        bias_trk  = (BW+1)'(bias_cur) + (BW+1)'(gain_prod >>> TRACK_SHIFT);
        bias_new  = track ? bias_trk[BW-1:0] : bias_cur;

        diff_new = (BW+1)'(rfx) - (BW+1)'(bias_new);
        prod     = PW'(diff_new) * PW'($signed({1'b0, dt}));
        prod_rnd = prod + (PW'(1) <<< (BIAS_FRAC_BITS - 1));
        inc_full = prod_rnd >>> BIAS_FRAC_BITS;

        // truncating modulo 360 deg; |sum| < 3 turns
        sum = SUM_W'(yaw_cur) + SUM_W'(inc_full);
        if (sum >= TURN2)
            wrapped = sum - TURN2;
        else if (sum >= TURN1)
            wrapped = sum - TURN1;
        else if (sum <= -TURN2)
            wrapped = sum + TURN2;
        else if (sum <= -TURN1)
            wrapped = sum + TURN1;
        else
            wrapped = sum;

        yaw_new     = sample ? YAW_W'(wrapped) : '0;
        flags.still = still;
        flags.track = track;
    end

endmodule

`default_nettype wire

[design/gyro_yaw_integrator_bias_track_unit.sv]
// Gyro yaw integrator with zero-rate bias tracking.
// Input channel (in_valid / in_stall): one word per gyro sample or yaw-reset
// command, fields req_type, rate, timestamp_ms. Output channel (out_valid /
// out_stall): one result word per input word: yaw, bias_estimate, still.
// Config port (cfg_we / cfg_index / cfg_wdata): threshold, hold time and
// initial bias; writing the initial bias also loads the bias estimate.
// Write config only while no word is in flight.
// Flow: a word accepted is registered in the input register, then computed
// and written to the state/result registers, which drive the output.
// Throughput: one word per cycle while out_stall is low. The whole update
// (bias step, one (rate - bias) * dt multiply, yaw add and 360 degree wrap)
// sits between the input register and the state/result registers.
// Stall: the output word holds while out_stall is high; one more word waits in
// the input register, then in_stall rises.
// Reset: yaw, times and stillness clear, bias estimate returns to zero,
// threshold 128 and hold 100 ms.

`default_nettype none

module gyro_yaw_integrator_bias_track_unit
    import gyib_pkg::*;
#(
    parameter int BIAS_FRAC_BITS = BIAS_FRAC_BITS_DEF,
    parameter int DT_MAX_MS      = DT_MAX_MS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // config write port
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_W-1:0]         cfg_wdata,
    // input words
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic                     req_type,
    input  wire logic signed [RATE_W-1:0] rate,
    input  wire logic [TS_W-1:0]          timestamp_ms,
    // result words
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [YAW_W-1:0]       yaw,
    output logic signed [RATE_W-1:0]      bias_estimate,
    output logic                          still
);

`include "gyro_yaw_integrator_bias_track_unit_defines.svh"

    localparam int BW = RATE_W + BIAS_FRAC_BITS;

    // config
    logic [THR_W-1:0]  threshold_reg;
    logic [HOLD_W-1:0] hold_reg;

    // input stage
    logic                     s1_valid_reg;
    logic                     s1_req_reg;
    logic signed [RATE_W-1:0] s1_rate_reg;
    logic [TS_W-1:0]          s1_time_reg;

    // integrator state; yaw and bias also serve as the result
    logic signed [YAW_W-1:0] yaw_accum_reg;
    logic signed [BW-1:0]    bias_accum_reg;
    logic [TS_W-1:0]         last_time_reg;
    logic [TS_W-1:0]         still_start_reg;
    logic                    was_still_reg;

    logic out_valid_reg;
    logic still_reg;

    logic                    in_take;
    logic                    advance;
    logic                    fire;
    logic                    is_sample;
    logic signed [YAW_W-1:0] yaw_calc;
    logic signed [BW-1:0]    bias_calc;
    gyib_flags_t             flags;

    logic signed [YAW_W-1:0] yaw_accum_next;
    logic signed [BW-1:0]    bias_accum_next;
    logic [TS_W-1:0]         last_time_next;
    logic [TS_W-1:0]         still_start_next;
    logic                    was_still_next;

    // handshake: result register frees when empty or taken
    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;
    assign is_sample = (s1_req_reg == REQ_SAMPLE);

    gyib_calc #(
        .BIAS_FRAC_BITS (BIAS_FRAC_BITS),
        .DT_MAX_MS      (DT_MAX_MS)
    ) u_calc (
        .req_type    (s1_req_reg),
        .rate        (s1_rate_reg),
        .now         (s1_time_reg),
        .yaw_cur     (yaw_accum_reg),
        .bias_cur    (bias_accum_reg),
        .last_time   (last_time_reg),
        .still_start (still_start_reg),
        .was_still   (was_still_reg),
        .threshold   (threshold_reg),
        .hold        (hold_reg),
        .yaw_new     (yaw_calc),
        .bias_new    (bias_calc),
        .flags       (flags)
    );

    always_comb
    begin
        yaw_accum_next   = yaw_accum_reg;
        bias_accum_next  = bias_accum_reg;
        last_time_next   = last_time_reg;
        still_start_next = still_start_reg;
        was_still_next   = was_still_reg;

        if (fire)
        begin
            yaw_accum_next  = yaw_calc;
            bias_accum_next = bias_calc;
            last_time_next  = s1_time_reg;
            // yaw reset keeps the stillness tracking as it is
            if (is_sample)
            begin
                was_still_next = flags.still;
                if (flags.still && !was_still_reg)
                    still_start_next = s1_time_reg;
            end
        end

        // initial-bias write reloads estimate; user keeps block idle, not enforced
        if (cfg_we && (cfg_index == REG_INIT_BIAS))
            bias_accum_next = $signed({cfg_wdata, {BIAS_FRAC_BITS{1'b0}}});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= THR_RESET;
            hold_reg        <= HOLD_RESET;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            yaw_accum_reg   <= '0;
            bias_accum_reg  <= '0;
            last_time_reg   <= '0;
            still_start_reg <= '0;
            was_still_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_THRESHOLD: threshold_reg <= cfg_wdata[THR_W-1:0];
                    REG_HOLD:      hold_reg      <= cfg_wdata[HOLD_W-1:0];
                    REG_INIT_BIAS: ;
                    default:       ;
                endcase
            end

            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (fire)
                s1_valid_reg <= 1'b0;

            out_valid_reg <= fire || (out_valid_reg && out_stall);

            yaw_accum_reg   <= yaw_accum_next;
            bias_accum_reg  <= bias_accum_next;
            last_time_reg   <= last_time_next;
            still_start_reg <= still_start_next;
            was_still_reg   <= was_still_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_req_reg  <= req_type;
            s1_rate_reg <= rate;
            s1_time_reg <= timestamp_ms;
        end
        if (fire)
            still_reg <= flags.still;
    end

    assign out_valid     = out_valid_reg;
    assign yaw           = yaw_accum_reg;
    assign bias_estimate = bias_accum_reg[BIAS_FRAC_BITS +: RATE_W];
    assign still         = still_reg;

    `GYIB_ASSERT_NEXT(a_yaw_reset_result, fire && !is_sample,
        (yaw == '0) && !still, "yaw reset word did not give zero yaw and still low")

    `GYIB_ASSERT_NOW(a_yaw_range, out_valid_reg,
        (yaw < YAW_W'(YAW_FULL_TURN)) && (yaw > -YAW_W'(YAW_FULL_TURN)), "yaw outside one turn")

    `GYIB_ASSERT_NEXT(a_still_run_ends, fire && is_sample && !flags.still,
        !was_still_reg, "still run not cleared by a moving sample")

    `GYIB_ASSERT_NEXT(a_bias_held, fire && !flags.track && !cfg_we,
        $stable(bias_accum_reg), "bias moved without tracking")

endmodule

`default_nettype wire
